// ----- rtl/ikf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ikf_pkg
// Shared types, constants and helper functions for the roll/pitch filter.
// ----------------------------------------------------------------------------
package ikf_pkg;

  localparam int CORDIC_ITER_DEF = 16;
  localparam int CORDIC_MAX_ITER = 24;

  localparam int CORD_IN_W  = 25;
  localparam int CORD_XY_W  = 35;
  localparam int ANG_W      = 32;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 66;
  localparam int SQ_IN_W    = 48;
  localparam int SQ_OUT_W   = 24;
  localparam int SQ_STEPS   = 24;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_ANGLE  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAIN = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN  = 4'd3;

  localparam logic [CFG_W-1:0] STEP_TIME_RST  = 16'd655;
  localparam logic [CFG_W-1:0] YAW_ANGLE_RST  = 16'd0;
  localparam logic [CFG_W-1:0] ANGLE_GAIN_RST = 16'd6226;
  localparam logic [CFG_W-1:0] RATE_GAIN_RST  = 16'd49152;

  // Angles inside the CORDIC are in units of 2^-20 degree.
  localparam logic signed [ANG_W-1:0]     DEG90         = 32'sd94371840;
  localparam logic signed [ANG_W-1:0]     DEG180        = 32'sd188743680;
  localparam logic signed [CORD_XY_W-1:0] CORD_INV_GAIN = 35'sd652032874;
  localparam logic signed [MUL_W-1:0]     RAD2DEG_K     = 33'sd3754936;

  typedef struct packed {
    logic                        start;
    logic                        vect;
    logic signed [CORD_IN_W-1:0] x;
    logic signed [CORD_IN_W-1:0] y;
    logic signed [15:0]          ang;
  } cord_req_t;

  typedef struct packed {
    logic                    busy;
    logic signed [ANG_W-1:0] ang;
    logic signed [ANG_W-1:0] cos_v;
    logic signed [ANG_W-1:0] sin_v;
  } cord_rsp_t;

  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ANG_W-1:0] r;
    case (idx)
      5'd0:    r = 32'sd47185920;
      5'd1:    r = 32'sd27855475;
      5'd2:    r = 32'sd14718068;
      5'd3:    r = 32'sd7471121;
      5'd4:    r = 32'sd3750058;
      5'd5:    r = 32'sd1876857;
      5'd6:    r = 32'sd938658;
      5'd7:    r = 32'sd469357;
      5'd8:    r = 32'sd234682;
      5'd9:    r = 32'sd117342;
      5'd10:   r = 32'sd58671;
      5'd11:   r = 32'sd29335;
      5'd12:   r = 32'sd14668;
      5'd13:   r = 32'sd7334;
      5'd14:   r = 32'sd3667;
      5'd15:   r = 32'sd1833;
      5'd16:   r = 32'sd917;
      5'd17:   r = 32'sd458;
      5'd18:   r = 32'sd229;
      5'd19:   r = 32'sd115;
      5'd20:   r = 32'sd57;
      5'd21:   r = 32'sd29;
      5'd22:   r = 32'sd14;
      5'd23:   r = 32'sd7;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // Round half up, then arithmetic shift right.
  function automatic logic signed [PROD_W-1:0] rnd_shr(input logic signed [PROD_W-1:0] v,
                                                       input int n);
    logic signed [PROD_W-1:0] half;
    half = 66'sd1 <<< (n - 1);
    return (v + half) >>> n;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] v);
    logic signed [15:0] r;
    if (v > 66'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -66'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ikf_cordic.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ikf_cordic
// Iterative CORDIC, one micro-rotation per cycle: vectoring for atan2 and
// rotation for sine/cosine.
// ----------------------------------------------------------------------------
module ikf_cordic #(
  parameter int ITERS = ikf_pkg::CORDIC_ITER_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  ikf_pkg::cord_req_t   req,
  output ikf_pkg::cord_rsp_t   rsp
);
  import ikf_pkg::*;

  localparam logic [4:0] LAST = 5'(ITERS - 1);

  logic signed [CORD_XY_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ANG_W-1:0]     z_r, z_nxt;
  logic [4:0]                  i_r, i_nxt;
  logic                        busy_r, busy_nxt;
  logic                        vect_r, vect_nxt;
  logic                        neg_r, neg_nxt;
  logic                        zero_r, zero_nxt;

  logic signed [CORD_XY_W-1:0] xs, ys, xe, ye, xo, yo;
  logic signed [ANG_W-1:0]     za, at;
  logic                        add;

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    busy_nxt = busy_r;
    vect_nxt = vect_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    xs  = x_r >>> i_r;
    ys  = y_r >>> i_r;
    at  = atan_lut(i_r);
    add = vect_r ? ~y_r[CORD_XY_W-1] : z_r[ANG_W-1];
    xe  = CORD_XY_W'(req.x);
    ye  = CORD_XY_W'(req.y);
    za  = {{3{req.ang[15]}}, req.ang, 13'b0};
    if (req.start) begin
      busy_nxt = 1'b1;
      i_nxt    = 5'd0;
      vect_nxt = req.vect;
      neg_nxt  = 1'b0;
      zero_nxt = 1'b0;
      if (req.vect) begin
        zero_nxt = (xe == '0) && (ye == '0);
        if (xe[CORD_XY_W-1]) begin
          z_nxt = ye[CORD_XY_W-1] ? -DEG180 : DEG180;
          x_nxt = -xe;
          y_nxt = -ye;
        end else begin
          z_nxt = '0;
          x_nxt = xe;
          y_nxt = ye;
        end
      end else begin
        // Fold the angle into +-90 degrees; results are negated at the end.
        if (za > DEG90) begin
          z_nxt   = za - DEG180;
          neg_nxt = 1'b1;
        end else if (za < -DEG90) begin
          z_nxt   = za + DEG180;
          neg_nxt = 1'b1;
        end else begin
          z_nxt = za;
        end
        x_nxt = CORD_INV_GAIN;
        y_nxt = '0;
      end
    end else if (busy_r) begin
      if (add) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end
      i_nxt = i_r + 5'd1;
      if (i_r == LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      i_r    <= i_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    vect_r <= vect_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
  end

  assign xo        = neg_r ? -x_r : x_r;
  assign yo        = neg_r ? -y_r : y_r;
  assign rsp.busy  = busy_r;
  assign rsp.ang   = zero_r ? '0 : z_r;
  assign rsp.cos_v = xo[ANG_W-1:0];
  assign rsp.sin_v = yo[ANG_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/ikf_isqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ikf_isqrt
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ikf_isqrt (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  input  wire  [ikf_pkg::SQ_IN_W-1:0]    value,
  output logic                           busy,
  output logic [ikf_pkg::SQ_OUT_W-1:0]   root
);
  import ikf_pkg::*;

  localparam logic [4:0] LAST = 5'(SQ_STEPS - 1);

  logic [SQ_IN_W-1:0]  val_r, val_nxt;
  logic [26:0]         rem_r, rem_nxt;
  logic [SQ_OUT_W-1:0] root_r, root_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic [26:0]         rem_sh, trial;

  always_comb begin
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    rem_sh   = {rem_r[24:0], val_r[SQ_IN_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    if (start) begin
      val_nxt  = value;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      val_nxt = {val_r[SQ_IN_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[SQ_OUT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[SQ_OUT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule
`default_nettype wire

// ----- rtl/imu_roll_pitch_fixed_gain_kalman.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// imu_roll_pitch_fixed_gain_kalman
// Steady-state roll/pitch Kalman filter for one IMU sample per item.
// ----------------------------------------------------------------------------
// One item is one IMU sample (three accelerometer axes, two gyro rates). The
// block works on one item at a time and takes these steps in order: forming
// ay^2 + az^2, waiting on the 24-step square root (the roll atan2 runs
// alongside it in the shared CORDIC unit), the three further CORDIC passes
// (pitch atan2, then sine/cosine of the pitch estimate and of the yaw angle),
// 17 steps through one shared 33x33 multiplier, handing the result over once
// the output register is free, and the idle state in which the next item is
// taken. in_stall stays high from the accepted item until its result has been
// written into the output register; the result then waits there while the
// next item is taken. Configuration registers may be written at any time the
// block is idle. Filtered angles and rate states saturate at 16 bits;
// measured angles are clamped to their physical range.
// ----------------------------------------------------------------------------
module imu_roll_pitch_fixed_gain_kalman #(
  parameter int CORDIC_ITERATIONS = ikf_pkg::CORDIC_ITER_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_wr_en,
  input  wire  [ikf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [ikf_pkg::CFG_W-1:0]       cfg_wr_data,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  signed [15:0]              in_accel_x,
  input  wire  signed [15:0]              in_accel_y,
  input  wire  signed [15:0]              in_accel_z,
  input  wire  signed [15:0]              in_gyro_x,
  input  wire  signed [15:0]              in_gyro_y,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic signed [15:0]              out_measured_roll,
  output logic signed [14:0]              out_measured_pitch,
  output logic signed [15:0]              out_filtered_roll,
  output logic signed [15:0]              out_filtered_pitch
);
  import ikf_pkg::*;

  // Sequencer states. W* states wait on the CORDIC / square root units, M*
  // states each issue one product and, from M2 on, consume the one issued before.
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SQ0  = 5'd1;
  localparam logic [4:0] ST_SQ1  = 5'd2;
  localparam logic [4:0] ST_SQ2  = 5'd3;
  localparam logic [4:0] ST_W1   = 5'd4;
  localparam logic [4:0] ST_W2   = 5'd5;
  localparam logic [4:0] ST_W3   = 5'd6;
  localparam logic [4:0] ST_W4   = 5'd7;
  localparam logic [4:0] ST_M1   = 5'd8;
  localparam logic [4:0] ST_M2   = 5'd9;
  localparam logic [4:0] ST_M3   = 5'd10;
  localparam logic [4:0] ST_M4   = 5'd11;
  localparam logic [4:0] ST_M5   = 5'd12;
  localparam logic [4:0] ST_M6   = 5'd13;
  localparam logic [4:0] ST_M7   = 5'd14;
  localparam logic [4:0] ST_M8   = 5'd15;
  localparam logic [4:0] ST_M9   = 5'd16;
  localparam logic [4:0] ST_M10  = 5'd17;
  localparam logic [4:0] ST_M11  = 5'd18;
  localparam logic [4:0] ST_M12  = 5'd19;
  localparam logic [4:0] ST_M13  = 5'd20;
  localparam logic [4:0] ST_M14  = 5'd21;
  localparam logic [4:0] ST_M15  = 5'd22;
  localparam logic [4:0] ST_M16  = 5'd23;
  localparam logic [4:0] ST_M17  = 5'd24;
  localparam logic [4:0] ST_FIN  = 5'd25;

  localparam logic signed [PROD_W-1:0] ROLL_LIM  = 66'sd23040;
  localparam logic signed [PROD_W-1:0] PITCH_LIM = 66'sd11520;

  // Clamp a value to +-lim and return it as 16 bits.
  function automatic logic signed [15:0] clamp_lim(input logic signed [PROD_W-1:0] v,
                                                   input logic signed [PROD_W-1:0] lim);
    logic signed [PROD_W-1:0] r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r[15:0];
  endfunction

  // Configuration registers.
  logic [CFG_W-1:0]        step_time_r, angle_gain_r, rate_gain_r;
  logic signed [CFG_W-1:0] yaw_r;

  // Sequencer and datapath registers.
  logic [4:0]               state_r, state_nxt;
  logic signed [15:0]       ax_r, ay_r, az_r, gx_r, gy_r;
  logic signed [15:0]       ax_nxt, ay_nxt, az_nxt, gx_nxt, gy_nxt;
  logic signed [PROD_W-1:0] acc_r, acc_nxt, p_r;
  logic signed [15:0]       mroll_r, mroll_nxt, mpitch_r, mpitch_nxt;
  logic signed [ANG_W-1:0]  cp_r, cp_nxt, sy_r, sy_nxt, cy_r, cy_nxt;
  logic signed [MUL_W-1:0]  cpcy_r, cpcy_nxt, sycp_r, sycp_nxt;
  logic signed [48:0]       t1_r, t1_nxt, t2_r, t2_nxt;
  logic signed [23:0]       proll_r, proll_nxt, ppitch_r, ppitch_nxt;
  logic signed [15:0]       mrx_r, mrx_nxt, mry_r, mry_nxt;
  logic signed [15:0]       roll_est_r, roll_est_nxt, pitch_est_r, pitch_est_nxt;
  logic signed [15:0]       rr_r, rr_nxt, pr_r, pr_nxt;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  logic signed [15:0]       o_mroll_r, o_mroll_nxt, o_froll_r, o_froll_nxt;
  logic signed [15:0]       o_fpitch_r, o_fpitch_nxt;
  logic signed [14:0]       o_mpitch_r, o_mpitch_nxt;

  // Shared multiplier: operands chosen by the sequencer, product registered.
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] tmp;

  cord_req_t              cord_req;
  cord_rsp_t              cord_rsp;
  logic                   sq_start;
  logic [SQ_IN_W-1:0]     sq_value;
  logic                   sq_busy;
  logic [SQ_OUT_W-1:0]    sq_root;
  logic                   units_idle;
  logic                   in_acc;

  ikf_cordic #(
    .ITERS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cord_req),
    .rsp   (cord_rsp)
  );

  ikf_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (sq_value),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign units_idle = !cord_rsp.busy && !sq_busy;
  assign prod       = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Multiplier operand selection.
  always_comb begin
    mul_a = MUL_W'(mry_r);
    mul_b = MUL_W'({1'b0, rate_gain_r});
    case (state_r)
      ST_SQ0: begin
        mul_a = MUL_W'(ay_r);
        mul_b = MUL_W'(ay_r);
      end
      ST_SQ1: begin
        mul_a = MUL_W'(az_r);
        mul_b = MUL_W'(az_r);
      end
      ST_M1: begin
        mul_a = MUL_W'(cp_r);
        mul_b = MUL_W'(cy_r);
      end
      ST_M2: begin
        mul_a = MUL_W'(sy_r);
        mul_b = MUL_W'(cp_r);
      end
      ST_M3: begin
        mul_a = cpcy_r;
        mul_b = MUL_W'(rr_r);
      end
      ST_M4: begin
        mul_a = MUL_W'(sy_r);
        mul_b = MUL_W'(pr_r);
      end
      ST_M5: begin
        mul_a = sycp_r;
        mul_b = MUL_W'(rr_r);
      end
      ST_M6: begin
        mul_a = MUL_W'(cy_r);
        mul_b = MUL_W'(pr_r);
      end
      ST_M7: begin
        mul_a = MUL_W'($signed(t1_r[48:24]));
        mul_b = MUL_W'({1'b0, step_time_r});
      end
      ST_M8: begin
        mul_a = MUL_W'({1'b0, t1_r[23:0]});
        mul_b = MUL_W'({1'b0, step_time_r});
      end
      ST_M9: begin
        mul_a = MUL_W'($signed(t2_r[48:24]));
        mul_b = MUL_W'({1'b0, step_time_r});
      end
      ST_M10: begin
        mul_a = MUL_W'({1'b0, t2_r[23:0]});
        mul_b = MUL_W'({1'b0, step_time_r});
      end
      ST_M11: begin
        mul_a = MUL_W'(mroll_r) - MUL_W'(proll_r);
        mul_b = MUL_W'({1'b0, angle_gain_r});
      end
      ST_M12: begin
        mul_a = MUL_W'(mpitch_r) - MUL_W'(ppitch_r);
        mul_b = MUL_W'({1'b0, angle_gain_r});
      end
      ST_M13: begin
        mul_a = MUL_W'(gx_r);
        mul_b = RAD2DEG_K;
      end
      ST_M14: begin
        mul_a = MUL_W'(gy_r);
        mul_b = RAD2DEG_K;
      end
      ST_M15: begin
        mul_a = MUL_W'(mrx_r);
        mul_b = MUL_W'({1'b0, rate_gain_r});
      end
      default: begin
        mul_a = MUL_W'(mry_r);
        mul_b = MUL_W'({1'b0, rate_gain_r});
      end
    endcase
  end

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    az_nxt        = az_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    acc_nxt       = acc_r;
    mroll_nxt     = mroll_r;
    mpitch_nxt    = mpitch_r;
    cp_nxt        = cp_r;
    sy_nxt        = sy_r;
    cy_nxt        = cy_r;
    cpcy_nxt      = cpcy_r;
    sycp_nxt      = sycp_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    proll_nxt     = proll_r;
    ppitch_nxt    = ppitch_r;
    mrx_nxt       = mrx_r;
    mry_nxt       = mry_r;
    roll_est_nxt  = roll_est_r;
    pitch_est_nxt = pitch_est_r;
    rr_nxt        = rr_r;
    pr_nxt        = pr_r;
    out_valid_nxt = out_valid_r;
    o_mroll_nxt   = o_mroll_r;
    o_mpitch_nxt  = o_mpitch_r;
    o_froll_nxt   = o_froll_r;
    o_fpitch_nxt  = o_fpitch_r;
    tmp           = '0;
    cord_req      = '0;
    sq_start      = 1'b0;
    sq_value      = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ax_nxt    = in_accel_x;
          ay_nxt    = in_accel_y;
          az_nxt    = in_accel_z;
          gx_nxt    = in_gyro_x;
          gy_nxt    = in_gyro_y;
          state_nxt = ST_SQ0;
        end
      end
      ST_SQ0: begin
        state_nxt = ST_SQ1;
      end
      ST_SQ1: begin
        acc_nxt   = p_r;
        state_nxt = ST_SQ2;
      end
      ST_SQ2: begin
        // Radius for pitch: sqrt((ay^2 + az^2) * 65536), alongside roll atan2.
        tmp           = acc_r + p_r;
        sq_start      = 1'b1;
        sq_value      = {tmp[31:0], 16'b0};
        cord_req.start = 1'b1;
        cord_req.vect  = 1'b1;
        cord_req.y     = $signed({ay_r[15], ay_r, 8'b0});
        cord_req.x     = $signed({az_r[15], az_r, 8'b0});
        state_nxt      = ST_W1;
      end
      ST_W1: begin
        if (units_idle) begin
          tmp            = rnd_shr(PROD_W'(cord_rsp.ang), 13);
          mroll_nxt      = clamp_lim(tmp, ROLL_LIM);
          cord_req.start = 1'b1;
          cord_req.vect  = 1'b1;
          cord_req.y     = -$signed({ax_r[15], ax_r, 8'b0});
          cord_req.x     = $signed({1'b0, sq_root});
          state_nxt      = ST_W2;
        end
      end
      ST_W2: begin
        if (!cord_rsp.busy) begin
          tmp            = rnd_shr(PROD_W'(cord_rsp.ang), 13);
          mpitch_nxt     = clamp_lim(tmp, PITCH_LIM);
          cord_req.start = 1'b1;
          cord_req.ang   = pitch_est_r;
          state_nxt      = ST_W3;
        end
      end
      ST_W3: begin
        if (!cord_rsp.busy) begin
          cp_nxt         = cord_rsp.cos_v;
          cord_req.start = 1'b1;
          cord_req.ang   = yaw_r;
          state_nxt      = ST_W4;
        end
      end
      ST_W4: begin
        if (!cord_rsp.busy) begin
          sy_nxt    = cord_rsp.sin_v;
          cy_nxt    = cord_rsp.cos_v;
          state_nxt = ST_M1;
        end
      end
      ST_M1: begin
        state_nxt = ST_M2;
      end
      ST_M2: begin
        tmp       = rnd_shr(p_r, 30);
        cpcy_nxt  = tmp[MUL_W-1:0];
        state_nxt = ST_M3;
      end
      ST_M3: begin
        tmp       = rnd_shr(p_r, 30);
        sycp_nxt  = tmp[MUL_W-1:0];
        state_nxt = ST_M4;
      end
      ST_M4: begin
        acc_nxt   = p_r;
        state_nxt = ST_M5;
      end
      ST_M5: begin
        tmp       = acc_r - p_r;
        t1_nxt    = tmp[48:0];
        state_nxt = ST_M6;
      end
      ST_M6: begin
        acc_nxt   = p_r;
        state_nxt = ST_M7;
      end
      ST_M7: begin
        tmp       = acc_r + p_r;
        t2_nxt    = tmp[48:0];
        state_nxt = ST_M8;
      end
      ST_M8: begin
        acc_nxt   = p_r;
        state_nxt = ST_M9;
      end
      ST_M9: begin
        // t1*dt rebuilt from its high and low partial products.
        tmp       = PROD_W'(roll_est_r) + rnd_shr((acc_r <<< 24) + p_r, 44);
        proll_nxt = tmp[23:0];
        state_nxt = ST_M10;
      end
      ST_M10: begin
        acc_nxt   = p_r;
        state_nxt = ST_M11;
      end
      ST_M11: begin
        tmp        = PROD_W'(pitch_est_r) + rnd_shr((acc_r <<< 24) + p_r, 44);
        ppitch_nxt = tmp[23:0];
        state_nxt  = ST_M12;
      end
      ST_M12: begin
        roll_est_nxt = sat16(PROD_W'(proll_r) + rnd_shr(p_r, 16));
        state_nxt    = ST_M13;
      end
      ST_M13: begin
        pitch_est_nxt = sat16(PROD_W'(ppitch_r) + rnd_shr(p_r, 16));
        state_nxt     = ST_M14;
      end
      ST_M14: begin
        tmp       = rnd_shr(p_r, 22);
        mrx_nxt   = tmp[15:0];
        state_nxt = ST_M15;
      end
      ST_M15: begin
        tmp       = rnd_shr(p_r, 22);
        mry_nxt   = tmp[15:0];
        state_nxt = ST_M16;
      end
      ST_M16: begin
        rr_nxt    = sat16(rnd_shr(p_r, 16));
        state_nxt = ST_M17;
      end
      ST_M17: begin
        pr_nxt    = sat16(rnd_shr(p_r, 16));
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_mroll_nxt   = mroll_r;
          o_mpitch_nxt  = mpitch_r[14:0];
          o_froll_nxt   = roll_est_r;
          o_fpitch_nxt  = pitch_est_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Configuration writes; indexes past the register list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r  <= STEP_TIME_RST;
      yaw_r        <= YAW_ANGLE_RST;
      angle_gain_r <= ANGLE_GAIN_RST;
      rate_gain_r  <= RATE_GAIN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_STEP_TIME:  step_time_r  <= cfg_wr_data;
        CFG_YAW_ANGLE:  yaw_r        <= cfg_wr_data;
        CFG_ANGLE_GAIN: angle_gain_r <= cfg_wr_data;
        CFG_RATE_GAIN:  rate_gain_r  <= cfg_wr_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      roll_est_r  <= '0;
      pitch_est_r <= '0;
      rr_r        <= '0;
      pr_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      roll_est_r  <= roll_est_nxt;
      pitch_est_r <= pitch_est_nxt;
      rr_r        <= rr_nxt;
      pr_r        <= pr_nxt;
    end
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    az_r       <= az_nxt;
    gx_r       <= gx_nxt;
    gy_r       <= gy_nxt;
    acc_r      <= acc_nxt;
    p_r        <= prod;
    mroll_r    <= mroll_nxt;
    mpitch_r   <= mpitch_nxt;
    cp_r       <= cp_nxt;
    sy_r       <= sy_nxt;
    cy_r       <= cy_nxt;
    cpcy_r     <= cpcy_nxt;
    sycp_r     <= sycp_nxt;
    t1_r       <= t1_nxt;
    t2_r       <= t2_nxt;
    proll_r    <= proll_nxt;
    ppitch_r   <= ppitch_nxt;
    mrx_r      <= mrx_nxt;
    mry_r      <= mry_nxt;
    o_mroll_r  <= o_mroll_nxt;
    o_mpitch_r <= o_mpitch_nxt;
    o_froll_r  <= o_froll_nxt;
    o_fpitch_r <= o_fpitch_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_measured_roll  = o_mroll_r;
  assign out_measured_pitch = o_mpitch_r;
  assign out_filtered_roll  = o_froll_r;
  assign out_filtered_pitch = o_fpitch_r;

endmodule
`default_nettype wire
